// ===== src/tfn_pkg.sv =====
// Package for the triangle face normal block: fixed widths, word types and the
// per-item sideband that rides alongside the arithmetic pipeline.
// No dependencies.
package tfn_pkg;

  localparam int CoordWidth   = 16;
  localparam int NormFracBits = 14;
  localparam int NormWidth    = NormFracBits + 2;
  localparam int NormOne      = 1 << NormFracBits;

  localparam int EdgeShift  = (CoordWidth + 1 > 31) ? CoordWidth - 30 : 0;
  localparam int EdgeWidth  = CoordWidth + 1 - EdgeShift;
  localparam int ProdWidth  = 2 * EdgeWidth;
  localparam int CrossWidth = 2 * EdgeWidth + 1;
  localparam int MagWidth   = 2 * EdgeWidth;

  localparam int MantWidth = 30;
  localparam int PadWidth  = (MagWidth > MantWidth) ? MagWidth : MantWidth;
  localparam int LzWidth   = $clog2(PadWidth + 1);
  localparam int SqWidth   = 2 * MantWidth;
  localparam int SumWidth  = SqWidth + 2;

  localparam int RootSteps = MantWidth + 1;
  localparam int RootWidth = MantWidth + 1;

  localparam int QuotWidth = NormFracBits + 1;
  localparam int NumWidth  = MantWidth + NormFracBits + 1;
  localparam int RemWidth  = RootWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [NormWidth-1:0]  norm_t;
  typedef logic signed [EdgeWidth-1:0]  edge_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic [PadWidth-1:0]          mag_t;
  typedef logic [LzWidth-1:0]           lz_t;
  typedef logic [MantWidth-1:0]         mant_t;
  typedef logic [SqWidth-1:0]           sq_t;
  typedef logic [SumWidth-1:0]          sum_t;
  typedef logic [RootWidth-1:0]         root_t;
  typedef logic [QuotWidth-1:0]         quot_t;
  typedef logic [NumWidth-1:0]          num_t;
  typedef logic [RemWidth-1:0]          rem_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_word_t;

  typedef struct packed {
    norm_t norm_x;
    norm_t norm_y;
    norm_t norm_z;
    logic  degenerate;
  } out_word_t;

  typedef struct packed {
    logic              degen;
    logic [2:0]        pos;
    mant_t [2:0]       m;
  } side_t;

endpackage

// ===== src/tfn_cross.sv =====
// Edge vectors and cross product, three register stages.
// Depends on tfn_pkg.
module tfn_cross (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  tfn_pkg::in_word_t in_word,
  output logic              out_vld,
  output tfn_pkg::cross_t   xprod [3]
);
  import tfn_pkg::*;

  function automatic edge_t edge_of(coord_t hi, coord_t lo);
    logic signed [CoordWidth:0] df;
    df = {hi[CoordWidth-1], hi} - {lo[CoordWidth-1], lo};
    return edge_t'(df >>> EdgeShift);
  endfunction

  edge_t  d_r [3];
  edge_t  e_r [3];
  prod_t  p_r [6];
  cross_t xprod_r [3];
  logic   v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= edge_of(in_word.bx, in_word.ax);
      d_r[1] <= edge_of(in_word.by, in_word.ay);
      d_r[2] <= edge_of(in_word.bz, in_word.az);
      e_r[0] <= edge_of(in_word.cx, in_word.ax);
      e_r[1] <= edge_of(in_word.cy, in_word.ay);
      e_r[2] <= edge_of(in_word.cz, in_word.az);

      p_r[0] <= prod_t'(d_r[1]) * prod_t'(e_r[2]);
      p_r[1] <= prod_t'(d_r[2]) * prod_t'(e_r[1]);
      p_r[2] <= prod_t'(d_r[2]) * prod_t'(e_r[0]);
      p_r[3] <= prod_t'(d_r[0]) * prod_t'(e_r[2]);
      p_r[4] <= prod_t'(d_r[0]) * prod_t'(e_r[1]);
      p_r[5] <= prod_t'(d_r[1]) * prod_t'(e_r[0]);

      xprod_r[0] <= cross_t'(p_r[0]) - cross_t'(p_r[1]);
      xprod_r[1] <= cross_t'(p_r[2]) - cross_t'(p_r[3]);
      xprod_r[2] <= cross_t'(p_r[4]) - cross_t'(p_r[5]);
    end
  end

  assign out_vld = v3_r;
  assign xprod   = xprod_r;

endmodule

// ===== src/tfn_norm.sv =====
// Magnitudes, common normalizing shift and sum of squares, five register stages.
// Depends on tfn_pkg.
module tfn_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  tfn_pkg::cross_t xprod [3],
  output logic            out_vld,
  output tfn_pkg::side_t  out_side,
  output tfn_pkg::sum_t   sum
);
  import tfn_pkg::*;

  function automatic mag_t abs_mag(cross_t v);
    logic [CrossWidth-1:0] t;
    t = v[CrossWidth-1] ? CrossWidth'(-v) : v;
    return PadWidth'(t[MagWidth-1:0]);
  endfunction

  function automatic lz_t lzc(mag_t v);
    lz_t  c;
    logic hit;
    c   = lz_t'(PadWidth);
    hit = 1'b0;
    for (int i = PadWidth - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        c   = lz_t'(PadWidth - 1 - i);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

  mag_t       mag4_r [3];
  logic [2:0] pos4_r;
  mag_t       mag5_r [3];
  logic [2:0] pos5_r;
  lz_t        lz5_r;
  logic       degen5_r;
  mant_t      m6_r [3];
  logic [2:0] pos6_r;
  logic       degen6_r;
  sq_t        sq7_r [3];
  side_t      side7_r;
  side_t      side8_r;
  sum_t       sum8_r;
  logic       v4_r, v5_r, v6_r, v7_r, v8_r;
  mag_t       or_all;

  assign or_all = mag4_r[0] | mag4_r[1] | mag4_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_vld;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag4_r[i] <= abs_mag(xprod[i]);
        pos4_r[i] <= !xprod[i][CrossWidth-1] && (xprod[i] != '0);
      end

      mag5_r   <= mag4_r;
      pos5_r   <= pos4_r;
      lz5_r    <= lzc(or_all);
      degen5_r <= (or_all == '0);

      for (int i = 0; i < 3; i++) begin
        m6_r[i] <= mant_t'((mag5_r[i] << lz5_r) >> (PadWidth - MantWidth));
      end
      pos6_r   <= pos5_r;
      degen6_r <= degen5_r;

      for (int i = 0; i < 3; i++) begin
        sq7_r[i]     <= sq_t'(m6_r[i]) * sq_t'(m6_r[i]);
        side7_r.m[i] <= m6_r[i];
      end
      side7_r.pos   <= pos6_r;
      side7_r.degen <= degen6_r;

      sum8_r  <= sum_t'(sq7_r[0]) + sum_t'(sq7_r[1]) + sum_t'(sq7_r[2]);
      side8_r <= side7_r;
    end
  end

  assign out_vld  = v8_r;
  assign out_side = side8_r;
  assign sum      = sum8_r;

endmodule

// ===== src/tfn_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on tfn_pkg.
module tfn_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  tfn_pkg::side_t in_side,
  input  tfn_pkg::sum_t  in_sum,
  output logic           out_vld,
  output tfn_pkg::side_t out_side,
  output tfn_pkg::root_t root
);
  import tfn_pkg::*;

  sum_t  rem_r  [RootSteps];
  sum_t  res_r  [RootSteps];
  side_t side_r [RootSteps];
  logic  vld_r  [RootSteps];

  genvar k;
  generate
    for (k = 0; k < RootSteps; k++) begin : g_step
      localparam sum_t Bit = sum_t'(1) << (2 * (RootSteps - 1 - k));
      sum_t  rem_in;
      sum_t  res_in;
      sum_t  trial;
      side_t side_in;
      logic  vld_in;

      if (k == 0) begin : g_first
        assign rem_in  = in_sum;
        assign res_in  = '0;
        assign side_in = in_side;
        assign vld_in  = in_vld;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign res_in  = res_r[k-1];
        assign side_in = side_r[k-1];
        assign vld_in  = vld_r[k-1];
      end

      assign trial = res_in + Bit;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side_r[k] <= side_in;
          if (rem_in >= trial) begin
            rem_r[k] <= rem_in - trial;
            res_r[k] <= (res_in >> 1) + Bit;
          end else begin
            rem_r[k] <= rem_in;
            res_r[k] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[RootSteps-1];
  assign out_side = side_r[RootSteps-1];
  assign root     = root_t'(res_r[RootSteps-1]);

endmodule

// ===== src/tfn_div.sv =====
// Three pipelined restoring dividers sharing one divisor, one quotient bit per stage.
// Depends on tfn_pkg.
module tfn_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  tfn_pkg::side_t in_side,
  input  tfn_pkg::root_t len,
  output logic           out_vld,
  output tfn_pkg::side_t out_side,
  output tfn_pkg::quot_t quot [3]
);
  import tfn_pkg::*;

  num_t  num0_r [3];
  root_t len0_r;
  side_t side0_r;
  logic  v0_r;

  rem_t  rem_r  [QuotWidth][3];
  quot_t q_r    [QuotWidth][3];
  quot_t lo_r   [QuotWidth][3];
  root_t len_r  [QuotWidth];
  side_t side_r [QuotWidth];
  logic  vld_r  [QuotWidth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num0_r[i] <= (num_t'(in_side.m[i]) << NormFracBits) + num_t'(len >> 1);
      end
      len0_r  <= len;
      side0_r <= in_side;
    end
  end

  genvar j;
  generate
    for (j = 0; j < QuotWidth; j++) begin : g_step
      rem_t  rem_in [3];
      quot_t q_in   [3];
      quot_t lo_in  [3];
      rem_t  trial  [3];
      logic  ge     [3];
      root_t len_in;
      side_t side_in;
      logic  vld_in;

      if (j == 0) begin : g_first
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            rem_in[i] = rem_t'(num0_r[i] >> QuotWidth);
            lo_in[i]  = num0_r[i][QuotWidth-1:0];
            q_in[i]   = '0;
          end
        end
        assign len_in  = len0_r;
        assign side_in = side0_r;
        assign vld_in  = v0_r;
      end else begin : g_next
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            rem_in[i] = rem_r[j-1][i];
            lo_in[i]  = lo_r[j-1][i];
            q_in[i]   = q_r[j-1][i];
          end
        end
        assign len_in  = len_r[j-1];
        assign side_in = side_r[j-1];
        assign vld_in  = vld_r[j-1];
      end

      always_comb begin
        for (int i = 0; i < 3; i++) begin
          trial[i] = {rem_in[i][RemWidth-2:0], lo_in[i][QuotWidth-1-j]};
          ge[i]    = (trial[i] >= rem_t'(len_in));
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            rem_r[j][i] <= ge[i] ? trial[i] - rem_t'(len_in) : trial[i];
            q_r[j][i]   <= {q_in[i][QuotWidth-2:0], ge[i]};
            lo_r[j][i]  <= lo_in[i];
          end
          len_r[j]  <= len_in;
          side_r[j] <= side_in;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[QuotWidth-1];
  assign out_side = side_r[QuotWidth-1];
  assign quot     = q_r[QuotWidth-1];

endmodule

// ===== src/triangle_face_normal.sv =====
// Triangle face normal: negated unit normal of three Q8.8 vertices, in Q1.14.
// One word per cycle sustained whenever the pipeline advances; in_stall is high otherwise.
// Depth is set by the 31-step square root and the 15-step dividers, one step per stage.
// All stages advance together whenever the output register is empty or being taken.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
module triangle_face_normal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfn_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tfn_pkg::out_word_t out_word
);
  import tfn_pkg::*;

  logic      adv;
  logic      cross_vld, norm_vld, root_vld, div_vld;
  cross_t    xprod [3];
  side_t     norm_side, root_side, div_side;
  sum_t      sum;
  root_t     root;
  quot_t     quot [3];
  norm_t     comp [3];
  out_word_t out_word_nxt;
  out_word_t out_word_r;
  logic      out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  tfn_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_word (in_word),
    .out_vld (cross_vld),
    .xprod   (xprod)
  );

  tfn_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (cross_vld),
    .xprod    (xprod),
    .out_vld  (norm_vld),
    .out_side (norm_side),
    .sum      (sum)
  );

  tfn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (norm_vld),
    .in_side  (norm_side),
    .in_sum   (sum),
    .out_vld  (root_vld),
    .out_side (root_side),
    .root     (root)
  );

  tfn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (root_vld),
    .in_side  (root_side),
    .len      (root),
    .out_vld  (div_vld),
    .out_side (div_side),
    .quot     (quot)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_side.degen) begin
        comp[i] = '0;
      end else if (div_side.pos[i]) begin
        comp[i] = -norm_t'(quot[i]);
      end else begin
        comp[i] = norm_t'(quot[i]);
      end
    end
    out_word_nxt.norm_x     = comp[0];
    out_word_nxt.norm_y     = comp[1];
    out_word_nxt.norm_z     = comp[2];
    out_word_nxt.degenerate = div_side.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.degenerate |->
      out_word_r.norm_x == '0 && out_word_r.norm_y == '0 && out_word_r.norm_z == '0)
    else $error("degenerate word carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_word_r.norm_x <= NormOne && out_word_r.norm_x >= -NormOne &&
      out_word_r.norm_y <= NormOne && out_word_r.norm_y >= -NormOne &&
      out_word_r.norm_z <= NormOne && out_word_r.norm_z >= -NormOne)
    else $error("normal component exceeds unit magnitude");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.degenerate |->
      !(out_word_r.norm_x == '0 && out_word_r.norm_y == '0 &&
        out_word_r.norm_z == '0))
    else $error("non-degenerate word has a zero normal");

endmodule
